// ===== hdl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg: shared types and codes of the obstacle avoid sequencer
// Holds the phase, motor and light codes, register indexes, reset values
// and the structs that pass between the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oas_pkg;

    // Drive phases.
    localparam logic [1:0] PH_FWD  = 2'd0;
    localparam logic [1:0] PH_BACK = 2'd1;
    localparam logic [1:0] PH_TURN = 2'd2;

    // Motor commands.
    localparam logic [2:0] M_HOLD = 3'd0;
    localparam logic [2:0] M_STOP = 3'd1;
    localparam logic [2:0] M_FWD  = 3'd2;
    localparam logic [2:0] M_BACK = 3'd3;
    localparam logic [2:0] M_ROTL = 3'd4;
    localparam logic [2:0] M_ROTR = 3'd5;

    // Light commands.
    localparam logic [2:0] L_HOLD  = 3'd0;
    localparam logic [2:0] L_BRAKE = 3'd1;
    localparam logic [2:0] L_TAIL  = 3'd2;
    localparam logic [2:0] L_REV   = 3'd3;
    localparam logic [2:0] L_LEFT  = 3'd4;
    localparam logic [2:0] L_RIGHT = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STOP_DIST  = 3'd0;
    localparam logic [2:0] REG_SLOW_DIST  = 3'd1;
    localparam logic [2:0] REG_REAR_CLEAR = 3'd2;
    localparam logic [2:0] REG_SIDE_CLEAR = 3'd3;
    localparam logic [2:0] REG_SIDE_MARGIN = 3'd4;
    localparam logic [2:0] REG_STABLE_HITS = 3'd5;
    localparam logic [2:0] REG_BACKUP_MS  = 3'd6;
    localparam logic [2:0] REG_BLINK_MS   = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_STOP_DIST   = 16'd200;
    localparam logic [15:0] RST_SLOW_DIST   = 16'd400;
    localparam logic [15:0] RST_REAR_CLEAR  = 16'd300;
    localparam logic [15:0] RST_SIDE_CLEAR  = 16'd300;
    localparam logic [15:0] RST_SIDE_MARGIN = 16'd50;
    localparam logic [7:0]  RST_STABLE_HITS = 8'd3;
    localparam logic [15:0] RST_BACKUP_MS   = 16'd500;
    localparam logic [15:0] RST_BLINK_MS    = 16'd300;

    // Saturation limit of the hit counter.
    localparam logic [7:0] HIT_MAX = 8'd255;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0] stop_distance;
        logic [15:0] slow_distance;
        logic [15:0] rear_clear_distance;
        logic [15:0] side_clear_distance;
        logic [15:0] side_margin;
        logic [7:0]  stable_hits;
        logic [15:0] backup_time_ms;
        logic [15:0] blink_period_ms;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] front_range;
        logic [15:0] rear_range;
        logic [15:0] left_range;
        logic [15:0] right_range;
        logic        restart;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0] motor_cmd;
        logic [7:0] motor_pwm;
        logic [2:0] light_cmd;
        logic       signal_on;
        logic [1:0] phase;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/obstacle_avoid_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer_unit: obstacle avoiding drive sequencer
// Takes one range and time item per control tick and returns the motor and
// light commands of that tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Contents
//  s         in         tvalid/tready       time, four ranges, restart flag
//  m         out        tvalid/tready       motor, pwm, light, signal, phase
//  apb       in/out     psel/penable/pready eight configuration registers
//
//  One item is accepted per cycle while the result channel is not stalled;
//  an item passes through the input register and then the result register,
//  with the combinational decision logic between them.
//  Synchronous active-low reset clears the sequencer state and loads the
//  register defaults.
//  A stalled result holds in its register; the input register still fills,
//  so the input stalls only when both registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obstacle_avoid_sequencer_unit #(
    parameter int TURN_LEFT_MS  = 600,
    parameter int TURN_RIGHT_MS = 600,
    parameter int PWM_FAST      = 200,
    parameter int PWM_SLOW      = 120,
    parameter int PWM_REVERSE   = 150,
    parameter int PWM_ROTATE    = 180
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input item channel.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // now_ms[31:0], front_range[47:32], rear_range[63:48],
    // left_range[79:64], right_range[95:80]
    input  wire logic [95:0] i_s_tdata,
    // restart[0]
    input  wire logic [0:0]  i_s_tuser,
    // Result item channel.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // motor_cmd[2:0], motor_pwm[10:3], light_cmd[13:11], signal_on[14],
    // phase[16:15], zero[23:17]
    output logic [23:0]      o_m_tdata,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    oas_pkg::t_cfg     cfg;
    oas_pkg::t_in_item r_in;
    oas_pkg::t_result  core_result;
    oas_pkg::t_result  r_out;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              advance;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    oas_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    oas_core #(
        .TURN_LEFT_MS  (TURN_LEFT_MS),
        .TURN_RIGHT_MS (TURN_RIGHT_MS),
        .PWM_FAST      (PWM_FAST),
        .PWM_SLOW      (PWM_SLOW),
        .PWM_REVERSE   (PWM_REVERSE),
        .PWM_ROTATE    (PWM_ROTATE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.now_ms      <= i_s_tdata[31:0];
            r_in.front_range <= i_s_tdata[47:32];
            r_in.rear_range  <= i_s_tdata[63:48];
            r_in.left_range  <= i_s_tdata[79:64];
            r_in.right_range <= i_s_tdata[95:80];
            r_in.restart     <= i_s_tuser[0];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.phase, r_out.signal_on, r_out.light_cmd,
                         r_out.motor_pwm, r_out.motor_cmd};

endmodule

`default_nettype wire

// ===== hdl/oas_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// oas_cfg_regs: configuration register file
// APB-style slave holding the eight thresholds and timing values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oas_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output oas_pkg::t_cfg      o_cfg
);

    oas_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_distance       <= oas_pkg::RST_STOP_DIST;
            r_cfg.slow_distance       <= oas_pkg::RST_SLOW_DIST;
            r_cfg.rear_clear_distance <= oas_pkg::RST_REAR_CLEAR;
            r_cfg.side_clear_distance <= oas_pkg::RST_SIDE_CLEAR;
            r_cfg.side_margin         <= oas_pkg::RST_SIDE_MARGIN;
            r_cfg.stable_hits         <= oas_pkg::RST_STABLE_HITS;
            r_cfg.backup_time_ms      <= oas_pkg::RST_BACKUP_MS;
            r_cfg.blink_period_ms     <= oas_pkg::RST_BLINK_MS;
        end else if (wr_en) begin
            case (reg_idx)
                oas_pkg::REG_STOP_DIST:   r_cfg.stop_distance       <= pwdata[15:0];
                oas_pkg::REG_SLOW_DIST:   r_cfg.slow_distance       <= pwdata[15:0];
                oas_pkg::REG_REAR_CLEAR:  r_cfg.rear_clear_distance <= pwdata[15:0];
                oas_pkg::REG_SIDE_CLEAR:  r_cfg.side_clear_distance <= pwdata[15:0];
                oas_pkg::REG_SIDE_MARGIN: r_cfg.side_margin         <= pwdata[15:0];
                oas_pkg::REG_STABLE_HITS: r_cfg.stable_hits         <= pwdata[7:0];
                oas_pkg::REG_BACKUP_MS:   r_cfg.backup_time_ms      <= pwdata[15:0];
                oas_pkg::REG_BLINK_MS:    r_cfg.blink_period_ms     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data, zero extended.
    always_comb begin
        case (reg_idx)
            oas_pkg::REG_STOP_DIST:   prdata = {16'd0, r_cfg.stop_distance};
            oas_pkg::REG_SLOW_DIST:   prdata = {16'd0, r_cfg.slow_distance};
            oas_pkg::REG_REAR_CLEAR:  prdata = {16'd0, r_cfg.rear_clear_distance};
            oas_pkg::REG_SIDE_CLEAR:  prdata = {16'd0, r_cfg.side_clear_distance};
            oas_pkg::REG_SIDE_MARGIN: prdata = {16'd0, r_cfg.side_margin};
            oas_pkg::REG_STABLE_HITS: prdata = {24'd0, r_cfg.stable_hits};
            oas_pkg::REG_BACKUP_MS:   prdata = {16'd0, r_cfg.backup_time_ms};
            oas_pkg::REG_BLINK_MS:    prdata = {16'd0, r_cfg.blink_period_ms};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/oas_core.sv =====
// ----------------------------------------------------------------------------
// oas_core: sequencer state and per-item decision logic
// Holds the phase, hit count, turn side, start times and blink flag, and
// computes one result item from the registered input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oas_core #(
    parameter int TURN_LEFT_MS  = 600,
    parameter int TURN_RIGHT_MS = 600,
    parameter int PWM_FAST      = 200,
    parameter int PWM_SLOW      = 120,
    parameter int PWM_REVERSE   = 150,
    parameter int PWM_ROTATE    = 180
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire oas_pkg::t_cfg    i_cfg,
    input  wire oas_pkg::t_in_item i_item,
    output oas_pkg::t_result      o_result
);

    localparam logic [15:0] TurnLeftMs  = 16'(TURN_LEFT_MS);
    localparam logic [15:0] TurnRightMs = 16'(TURN_RIGHT_MS);
    localparam logic [7:0]  PwmFast     = 8'(PWM_FAST);
    localparam logic [7:0]  PwmSlow     = 8'(PWM_SLOW);
    localparam logic [7:0]  PwmReverse  = 8'(PWM_REVERSE);
    localparam logic [7:0]  PwmRotate   = 8'(PWM_ROTATE);

    logic [1:0]  r_phase,        n_phase;
    logic [7:0]  r_hit_count,    n_hit_count;
    logic        r_turn_left,    n_turn_left;
    logic [31:0] r_backup_start, n_backup_start;
    logic [31:0] r_turn_start,   n_turn_start;
    logic [31:0] r_last_toggle,  n_last_toggle;
    logic        r_blink,        n_blink;

    // State as seen after a restart request.
    logic [1:0] cur_phase;
    logic [7:0] cur_hits;
    logic       cur_blink;
    logic [7:0] hits_inc;

    // Comparisons on the readings and times.
    logic        front_stop, front_slow;
    logic        left_clear, right_clear, left_wins, avoid_left;
    logic        rear_clear, rear_stop;
    logic [31:0] backup_elapsed, toggle_elapsed, turn_elapsed;
    logic        backup_done, toggle_due, turn_done;
    logic [15:0] turn_ms;

    assign cur_phase = i_item.restart ? oas_pkg::PH_FWD : r_phase;
    assign cur_hits  = i_item.restart ? 8'd0 : r_hit_count;
    assign cur_blink = i_item.restart ? 1'b0 : r_blink;
    assign hits_inc  = (cur_hits != oas_pkg::HIT_MAX) ? cur_hits + 8'd1 : cur_hits;

    assign front_stop  = (i_item.front_range != 16'd0) &&
                         (i_item.front_range <= i_cfg.stop_distance);
    assign front_slow  = (i_item.front_range != 16'd0) &&
                         (i_item.front_range <= i_cfg.slow_distance);
    assign left_clear  = (i_item.left_range != 16'd0) &&
                         (i_item.left_range >= i_cfg.side_clear_distance);
    assign right_clear = (i_item.right_range != 16'd0) &&
                         (i_item.right_range >= i_cfg.side_clear_distance);
    assign left_wins   = {1'b0, i_item.left_range} >
                         ({1'b0, i_item.right_range} + {1'b0, i_cfg.side_margin});
    assign avoid_left  = (left_clear && right_clear) ? left_wins : left_clear;
    assign rear_clear  = (i_item.rear_range != 16'd0) &&
                         (i_item.rear_range >= i_cfg.rear_clear_distance);
    assign rear_stop   = (i_item.rear_range != 16'd0) &&
                         (i_item.rear_range <= i_cfg.stop_distance);

    // Elapsed times wrap modulo 2^32.
    assign backup_elapsed = i_item.now_ms - r_backup_start;
    assign toggle_elapsed = i_item.now_ms - r_last_toggle;
    assign turn_elapsed   = i_item.now_ms - r_turn_start;
    assign backup_done    = backup_elapsed >= {16'd0, i_cfg.backup_time_ms};
    assign toggle_due     = toggle_elapsed >= {16'd0, i_cfg.blink_period_ms};
    assign turn_ms        = r_turn_left ? TurnLeftMs : TurnRightMs;
    assign turn_done      = turn_elapsed >= {16'd0, turn_ms};

    // Phase decisions for one item.
    always_comb begin
        n_phase        = cur_phase;
        n_hit_count    = cur_hits;
        n_turn_left    = r_turn_left;
        n_backup_start = r_backup_start;
        n_turn_start   = r_turn_start;
        n_last_toggle  = r_last_toggle;
        n_blink        = cur_blink;
        o_result.motor_cmd = oas_pkg::M_HOLD;
        o_result.motor_pwm = 8'd0;
        o_result.light_cmd = i_item.restart ? oas_pkg::L_TAIL : oas_pkg::L_HOLD;
        case (cur_phase)
            oas_pkg::PH_FWD: begin
                if (front_stop) begin
                    o_result.motor_cmd = oas_pkg::M_STOP;
                    o_result.light_cmd = oas_pkg::L_BRAKE;
                    n_hit_count = hits_inc;
                    if (hits_inc >= i_cfg.stable_hits) begin
                        n_turn_left = avoid_left;
                        if (rear_clear) begin
                            // Rear is open: back away first.
                            n_phase        = oas_pkg::PH_BACK;
                            n_backup_start = i_item.now_ms;
                            o_result.motor_cmd = oas_pkg::M_BACK;
                            o_result.motor_pwm = PwmReverse;
                            o_result.light_cmd = oas_pkg::L_REV;
                        end else begin
                            // No room behind: turn in place now.
                            n_phase       = oas_pkg::PH_TURN;
                            n_turn_start  = i_item.now_ms;
                            n_last_toggle = i_item.now_ms;
                            n_blink       = 1'b1;
                            o_result.motor_cmd = avoid_left ? oas_pkg::M_ROTL
                                                            : oas_pkg::M_ROTR;
                            o_result.motor_pwm = PwmRotate;
                            o_result.light_cmd = avoid_left ? oas_pkg::L_LEFT
                                                            : oas_pkg::L_RIGHT;
                        end
                    end
                end else begin
                    n_hit_count = 8'd0;
                    o_result.motor_cmd = oas_pkg::M_FWD;
                    o_result.motor_pwm = front_slow ? PwmSlow : PwmFast;
                    o_result.light_cmd = oas_pkg::L_TAIL;
                end
            end
            oas_pkg::PH_BACK: begin
                if (rear_stop || backup_done) begin
                    n_phase       = oas_pkg::PH_TURN;
                    n_turn_start  = i_item.now_ms;
                    n_last_toggle = i_item.now_ms;
                    n_blink       = 1'b1;
                    o_result.motor_cmd = r_turn_left ? oas_pkg::M_ROTL : oas_pkg::M_ROTR;
                    o_result.motor_pwm = PwmRotate;
                    o_result.light_cmd = r_turn_left ? oas_pkg::L_LEFT : oas_pkg::L_RIGHT;
                end
            end
            default: begin
                // Turning: blink the signal, then end the turn on timeout.
                if (toggle_due) begin
                    n_last_toggle = i_item.now_ms;
                    n_blink       = ~r_blink;
                    o_result.light_cmd = r_turn_left ? oas_pkg::L_LEFT : oas_pkg::L_RIGHT;
                end
                if (turn_done) begin
                    o_result.motor_cmd = oas_pkg::M_STOP;
                    o_result.motor_pwm = 8'd0;
                    o_result.light_cmd = oas_pkg::L_TAIL;
                    n_phase     = oas_pkg::PH_FWD;
                    n_hit_count = 8'd0;
                end
            end
        endcase
        o_result.signal_on = n_blink;
        o_result.phase     = n_phase;
    end

    // State update when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= oas_pkg::PH_FWD;
            r_hit_count    <= 8'd0;
            r_turn_left    <= 1'b0;
            r_backup_start <= 32'd0;
            r_turn_start   <= 32'd0;
            r_last_toggle  <= 32'd0;
            r_blink        <= 1'b0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_hit_count    <= n_hit_count;
            r_turn_left    <= n_turn_left;
            r_backup_start <= n_backup_start;
            r_turn_start   <= n_turn_start;
            r_last_toggle  <= n_last_toggle;
            r_blink        <= n_blink;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/oas_checker.sv =====
// ----------------------------------------------------------------------------
// oas_checker: port-level checks of the sequencer
// Watches the result channel for held items and legal command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oas_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    // The reported phase is one of the three drive phases.
    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16:15] == oas_pkg::PH_FWD) ||
                       (o_m_tdata[16:15] == oas_pkg::PH_BACK) ||
                       (o_m_tdata[16:15] == oas_pkg::PH_TURN))
        else $error("illegal phase in result item");

    // Hold and stop commands carry no drive level.
    a_idle_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tdata[2:0] == oas_pkg::M_HOLD) ||
                       (o_m_tdata[2:0] == oas_pkg::M_STOP))
        |-> (o_m_tdata[10:3] == 8'd0))
        else $error("drive level set on hold or stop");

    // Ending a tick in the forward phase means driving ahead or stopping.
    a_fwd_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[16:15] == oas_pkg::PH_FWD)
        |-> (o_m_tdata[2:0] == oas_pkg::M_FWD) || (o_m_tdata[2:0] == oas_pkg::M_STOP))
        else $error("unexpected motor command in forward phase");

    // A backward motor command always comes with the reverse light and the backup phase.
    a_back_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == oas_pkg::M_BACK)
        |-> (o_m_tdata[13:11] == oas_pkg::L_REV) && (o_m_tdata[16:15] == oas_pkg::PH_BACK))
        else $error("backward motion without reverse light or backup phase");

endmodule

bind obstacle_avoid_sequencer_unit oas_checker u_oas_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
